@@ sv/lsth_pkg.sv @@
// Shared constants, types and helper functions for the lagged symbol tuple histogram.
package lsth_pkg;

  localparam int MAX_LAG    = 16;
  localparam int NUM_BINS   = 256;

  localparam int COUNT_W    = 32;
  localparam int SYM_W      = 3;
  localparam int CMD_W      = 2;
  localparam int BIN_W      = 8;
  localparam int VAL_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  localparam int WIN_AW     = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
  localparam int HEAD_DEPTH = (MAX_LAG > 1) ? MAX_LAG - 1 : 1;
  localparam int HEAD_AW    = (HEAD_DEPTH > 1) ? $clog2(HEAD_DEPTH) : 1;
  localparam int LAGV_W     = $clog2(MAX_LAG + 1);
  localparam int HIST_AW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int EXT_W      = BIN_W + HIST_AW;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TUPLE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CIRCULAR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAG1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LAG2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LAG3     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LAG4     = 3'd6;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_SHORT   = 2'd1,
    STAT_BAD_SYM = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIN,
    S_UPD,
    S_HEAD,
    S_HSHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [SYM_W-1:0] symbol;
    logic             last_symbol;
    logic [BIN_W-1:0] bin_index;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic [1:0]         status;
  } out_t;

  function automatic logic [2:0] clamp_1_4(input logic [2:0] v);
    logic [2:0] r;
    if (v == 3'd0) begin
      r = 3'd1;
    end else if (v > 3'd4) begin
      r = 3'd4;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [LAGV_W-1:0] clamp_lag(input logic [CFG_DATA_W-1:0] v);
    logic [LAGV_W-1:0] r;
    if (v == '0) begin
      r = LAGV_W'(1);
    end else if (int'(v) > MAX_LAG) begin
      r = LAGV_W'(MAX_LAG);
    end else begin
      r = LAGV_W'(v);
    end
    return r;
  endfunction

endpackage

@@ sv/lsth_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module lsth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/lagged_symbol_tuple_histogram.sv @@
// Top level: gapped tuple histogram with a RAM-based read-modify-write sequencer.
// A counted push or a read passes S_BIN, S_UPD and S_DONE before out_valid rises; a
// clear, an uncounted push or an unknown command goes straight to S_DONE. A circular
// final symbol adds S_HEAD, S_HSHIFT, S_BIN and S_UPD for each wrapped tuple, L-1 in
// all. One item is in work at a time: in_stall is high until the result leaves S_DONE.
// Reset (rst_n, synchronous) loads register defaults, clears the window and valid bits.
module lagged_symbol_tuple_histogram (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lsth_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lsth_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lsth_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lsth_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lsth_pkg::state_t state_r, state_nxt;

  logic [2:0]                      alpha_r;
  logic [2:0]                      tlen_r;
  logic                            circ_r;
  logic [lsth_pkg::CFG_DATA_W-1:0] lag_r [4];

  logic [lsth_pkg::VAL_W-1:0]      window_r [lsth_pkg::MAX_LAG];
  logic [31:0]                     seen_r;
  logic [lsth_pkg::NUM_BINS-1:0]   valid_r;
  logic [lsth_pkg::LAGV_W-1:0]     wrap_left_r;
  logic                            out_valid_r;

  logic [lsth_pkg::CMD_W-1:0]      cmd_r;
  logic [lsth_pkg::BIN_W-1:0]      bin_index_r;
  logic [lsth_pkg::HEAD_AW-1:0]    head_idx_r;
  logic [lsth_pkg::HIST_AW-1:0]    addr_r;
  logic                            hit_r;
  logic [lsth_pkg::COUNT_W-1:0]    count_r;
  lsth_pkg::status_t               status_r;
  lsth_pkg::out_t                  out_data_r;

  logic [2:0]                      a_c;
  logic [2:0]                      k_c;
  logic [lsth_pkg::LAGV_W-1:0]     lag_c [4];
  logic [lsth_pkg::LAGV_W-1:0]     big;
  logic                            in_xfer;
  logic                            out_free;
  logic                            sym_ok;
  logic [lsth_pkg::VAL_W-1:0]      sym_v;
  logic [31:0]                     seen_inc;
  logic                            n_ge_big;
  logic [lsth_pkg::BIN_W-1:0]      tuple_bin;
  logic [lsth_pkg::BIN_W-1:0]      lookup_bin;
  logic [lsth_pkg::EXT_W-1:0]      lookup_ext;
  logic                            hit;
  logic [lsth_pkg::HIST_AW-1:0]    haddr;
  logic [lsth_pkg::COUNT_W-1:0]    old_count;

  logic                            hist_we;
  logic [lsth_pkg::COUNT_W-1:0]    hist_wdata;
  logic [lsth_pkg::COUNT_W-1:0]    hist_rdata;
  logic                            head_we;
  logic [lsth_pkg::HEAD_AW-1:0]    head_waddr;
  logic [lsth_pkg::VAL_W-1:0]      head_rdata;
  logic                            load_out;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    a_c = lsth_pkg::clamp_1_4(alpha_r);
    k_c = lsth_pkg::clamp_1_4(tlen_r);
    big = lsth_pkg::LAGV_W'(1);
    for (int j = 0; j < 4; j++) begin
      lag_c[j] = lsth_pkg::clamp_lag(lag_r[j]);
      if (3'(j) < k_c && lag_c[j] > big) begin
        big = lag_c[j];
      end
    end
  end

  assign sym_ok   = (in_data.symbol != 3'd0) && (in_data.symbol <= a_c);
  assign sym_v    = lsth_pkg::VAL_W'(in_data.symbol - 3'd1);
  assign seen_inc = (&seen_r) ? seen_r : seen_r + 32'd1;
  assign n_ge_big = seen_inc >= 32'(big);

  always_comb begin
    logic [lsth_pkg::BIN_W-1:0]  acc;
    logic [6:0]                  w;
    logic [lsth_pkg::WIN_AW-1:0] widx;
    acc  = '0;
    w    = 7'd1;
    widx = '0;
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < k_c) begin
        widx = lsth_pkg::WIN_AW'(big - lag_c[j]);
        acc  = acc + lsth_pkg::BIN_W'(w) * lsth_pkg::BIN_W'(window_r[widx]);
        w    = 7'(w * 7'(a_c));
      end
    end
    tuple_bin = acc;
  end

  assign lookup_bin = (cmd_r == lsth_pkg::CMD_READ) ? bin_index_r : tuple_bin;
  assign lookup_ext = {{lsth_pkg::HIST_AW{1'b0}}, lookup_bin};
  assign hit        = lookup_ext < lsth_pkg::EXT_W'(lsth_pkg::NUM_BINS);
  assign haddr      = lookup_ext[lsth_pkg::HIST_AW-1:0];
  assign old_count  = valid_r[addr_r] ? hist_rdata : '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsth_pkg::S_IDLE: begin
        if (in_xfer) begin
          if ((in_data.command == lsth_pkg::CMD_PUSH && sym_ok && n_ge_big) ||
              in_data.command == lsth_pkg::CMD_READ) begin
            state_nxt = lsth_pkg::S_BIN;
          end else begin
            state_nxt = lsth_pkg::S_DONE;
          end
        end
      end
      lsth_pkg::S_BIN:    state_nxt = lsth_pkg::S_UPD;
      lsth_pkg::S_UPD: begin
        state_nxt = (wrap_left_r != '0) ? lsth_pkg::S_HEAD : lsth_pkg::S_DONE;
      end
      lsth_pkg::S_HEAD:   state_nxt = lsth_pkg::S_HSHIFT;
      lsth_pkg::S_HSHIFT: state_nxt = lsth_pkg::S_BIN;
      lsth_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = lsth_pkg::S_IDLE;
        end
      end
      default:            state_nxt = lsth_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state_r != lsth_pkg::S_IDLE);
    hist_we    = (state_r == lsth_pkg::S_UPD) && (cmd_r == lsth_pkg::CMD_PUSH) && hit_r;
    hist_wdata = (&old_count) ? old_count : old_count + lsth_pkg::COUNT_W'(1);
    head_we    = in_xfer && (in_data.command == lsth_pkg::CMD_PUSH) && sym_ok &&
                 (seen_r < 32'(lsth_pkg::HEAD_DEPTH));
    head_waddr = seen_r[lsth_pkg::HEAD_AW-1:0];
    load_out   = (state_r == lsth_pkg::S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsth_pkg::S_IDLE;
      alpha_r     <= 3'd4;
      tlen_r      <= 3'd2;
      circ_r      <= 1'b0;
      lag_r[0]    <= 5'd1;
      lag_r[1]    <= 5'd2;
      lag_r[2]    <= 5'd3;
      lag_r[3]    <= 5'd4;
      seen_r      <= '0;
      valid_r     <= '0;
      wrap_left_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < lsth_pkg::MAX_LAG; i++) begin
        window_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lsth_pkg::CFG_ALPHABET: alpha_r  <= cfg_data[2:0];
          lsth_pkg::CFG_TUPLE:    tlen_r   <= cfg_data[2:0];
          lsth_pkg::CFG_CIRCULAR: circ_r   <= cfg_data[0];
          lsth_pkg::CFG_LAG1:     lag_r[0] <= cfg_data;
          lsth_pkg::CFG_LAG2:     lag_r[1] <= cfg_data;
          lsth_pkg::CFG_LAG3:     lag_r[2] <= cfg_data;
          lsth_pkg::CFG_LAG4:     lag_r[3] <= cfg_data;
          default: ;
        endcase
      end

      if (in_xfer) begin
        wrap_left_r <= (in_data.command == lsth_pkg::CMD_PUSH && sym_ok &&
                        in_data.last_symbol && circ_r && n_ge_big) ?
                       big - lsth_pkg::LAGV_W'(1) : '0;
        case (in_data.command)
          lsth_pkg::CMD_CLEAR: begin
            valid_r <= '0;
            seen_r  <= '0;
            for (int i = 0; i < lsth_pkg::MAX_LAG; i++) begin
              window_r[i] <= '0;
            end
          end
          lsth_pkg::CMD_PUSH: begin
            if (sym_ok) begin
              for (int i = lsth_pkg::MAX_LAG - 1; i > 0; i--) begin
                window_r[i] <= window_r[i-1];
              end
              window_r[0] <= sym_v;
              seen_r      <= in_data.last_symbol ? '0 : seen_inc;
            end
          end
          default: ;
        endcase
      end

      if (hist_we) begin
        valid_r[addr_r] <= 1'b1;
      end

      if (state_r == lsth_pkg::S_HSHIFT) begin
        for (int i = lsth_pkg::MAX_LAG - 1; i > 0; i--) begin
          window_r[i] <= window_r[i-1];
        end
        window_r[0] <= head_rdata;
        wrap_left_r <= wrap_left_r - lsth_pkg::LAGV_W'(1);
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r       <= in_data.command;
      bin_index_r <= in_data.bin_index;
      count_r     <= '0;
      head_idx_r  <= '0;
      if (in_data.command == lsth_pkg::CMD_PUSH && !sym_ok) begin
        status_r <= lsth_pkg::STAT_BAD_SYM;
      end else if (in_data.command == lsth_pkg::CMD_PUSH && in_data.last_symbol &&
                   circ_r && !n_ge_big) begin
        status_r <= lsth_pkg::STAT_SHORT;
      end else begin
        status_r <= lsth_pkg::STAT_OK;
      end
    end
    if (state_r == lsth_pkg::S_BIN) begin
      addr_r <= haddr;
      hit_r  <= hit;
    end
    if (state_r == lsth_pkg::S_UPD && cmd_r == lsth_pkg::CMD_READ) begin
      count_r <= hit_r ? old_count : '0;
    end
    if (state_r == lsth_pkg::S_HSHIFT) begin
      head_idx_r <= head_idx_r + lsth_pkg::HEAD_AW'(1);
    end
    if (load_out) begin
      out_data_r.bin_count <= count_r;
      out_data_r.status    <= status_r;
    end
  end

  lsth_ram #(
    .WIDTH (lsth_pkg::COUNT_W),
    .DEPTH (lsth_pkg::NUM_BINS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (addr_r),
    .wdata (hist_wdata),
    .raddr (haddr),
    .rdata (hist_rdata)
  );

  lsth_ram #(
    .WIDTH (lsth_pkg::VAL_W),
    .DEPTH (lsth_pkg::HEAD_DEPTH)
  ) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (sym_v),
    .raddr (head_idx_r),
    .rdata (head_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_xfer_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != lsth_pkg::S_IDLE))
    else $error("accepted item did not start processing");

  a_head_needs_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lsth_pkg::S_HEAD) |-> (wrap_left_r != '0))
    else $error("head read without pending wrap tuple");

  a_hshift_to_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lsth_pkg::S_HSHIFT) |=> (state_r == lsth_pkg::S_BIN))
    else $error("wrap shift not followed by bin lookup");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == lsth_pkg::S_DONE))
    else $error("result raised outside completion state");

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for the lagged symbol tuple histogram: directed table, then random sequences.
`timescale 1ns / 100ps

module testbench;

  typedef logic [6:0][lsth_pkg::CFG_DATA_W-1:0] reg_set_t;

  typedef struct {
    bit               settings;
    reg_set_t         regs;
    lsth_pkg::in_t    item;
    bit               typed;
    lsth_pkg::out_t   want;
  } step_row_t;

  localparam logic [lsth_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_MAX   = 10;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  lsth_pkg::in_t                   in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  lsth_pkg::out_t                  out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [lsth_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lsth_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic [lsth_pkg::COUNT_W-1:0] bin_mirror [lsth_pkg::NUM_BINS];
  logic [1:0]                   window_syms [lsth_pkg::MAX_LAG];
  logic [1:0]                   head_syms [lsth_pkg::MAX_LAG-1];
  int unsigned                  seq_len;
  logic [2:0]                   alpha_reg;
  logic [2:0]                   tuple_reg;
  logic                         circ_reg;
  logic [4:0]                   lag_regs [4];

  lsth_pkg::out_t pending_counts [$];
  step_row_t      directed_rows [$];
  int             mismatch_count = 0;
  int unsigned    cycle_count = 0;
  int             send_idle = 32;
  int             recv_idle = 59;
  bit             hold_go = 1'b0;
  logic           hold_on = 1'b0;

  lagged_symbol_tuple_histogram u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned eff_alpha();
    return (alpha_reg == 0) ? 1 : (alpha_reg > 4) ? 4 : alpha_reg;
  endfunction

  function automatic int unsigned eff_tuple();
    return (tuple_reg == 0) ? 1 : (tuple_reg > 4) ? 4 : tuple_reg;
  endfunction

  function automatic int unsigned eff_lag(input int j);
    return (lag_regs[j] == 0) ? 1 :
           (lag_regs[j] > lsth_pkg::MAX_LAG) ? lsth_pkg::MAX_LAG : lag_regs[j];
  endfunction

  function automatic int unsigned span_now();
    int unsigned big;
    big = 1;
    for (int j = 0; j < eff_tuple(); j++) begin
      if (eff_lag(j) > big) big = eff_lag(j);
    end
    return big;
  endfunction

  function automatic void bump_bin(input int unsigned b);
    if (b < lsth_pkg::NUM_BINS && bin_mirror[b] != '1) bin_mirror[b]++;
  endfunction

  function automatic void reset_predictor();
    foreach (bin_mirror[i]) bin_mirror[i] = '0;
    foreach (window_syms[i]) window_syms[i] = '0;
    foreach (head_syms[i]) head_syms[i] = '0;
    seq_len = 0;
    alpha_reg = 3'd4;
    tuple_reg = 3'd2;
    circ_reg = 1'b0;
    for (int j = 0; j < 4; j++) lag_regs[j] = 5'(j + 1);
  endfunction

  function automatic void apply_reg(input logic [lsth_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [lsth_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      lsth_pkg::CFG_ALPHABET: alpha_reg = val[2:0];
      lsth_pkg::CFG_TUPLE:    tuple_reg = val[2:0];
      lsth_pkg::CFG_CIRCULAR: circ_reg = val[0];
      lsth_pkg::CFG_LAG1:     lag_regs[0] = val;
      lsth_pkg::CFG_LAG2:     lag_regs[1] = val;
      lsth_pkg::CFG_LAG3:     lag_regs[2] = val;
      lsth_pkg::CFG_LAG4:     lag_regs[3] = val;
      default: ;
    endcase
  endfunction

  function automatic lsth_pkg::out_t predict_tuple_step(input lsth_pkg::in_t it);
    lsth_pkg::out_t res;
    int unsigned    a, k, span, bin, w, n, p, x, s, j;
    int unsigned    lag [4];
    res = '0;
    a = eff_alpha();
    k = eff_tuple();
    span = span_now();
    for (j = 0; j < 4; j++) lag[j] = eff_lag(j);
    case (it.command)
      lsth_pkg::CMD_CLEAR: begin
        foreach (bin_mirror[i]) bin_mirror[i] = '0;
        foreach (window_syms[i]) window_syms[i] = '0;
        seq_len = 0;
      end
      lsth_pkg::CMD_READ: res.bin_count = bin_mirror[it.bin_index];
      lsth_pkg::CMD_PUSH: begin
        if (it.symbol < 1 || it.symbol > a) begin
          res.status = lsth_pkg::STAT_BAD_SYM;
        end else begin
          for (j = lsth_pkg::MAX_LAG - 1; j > 0; j--) window_syms[j] = window_syms[j-1];
          window_syms[0] = 2'(it.symbol - 1);
          if (seq_len < lsth_pkg::MAX_LAG - 1) head_syms[seq_len] = window_syms[0];
          if (seq_len != 32'hFFFF_FFFF) seq_len++;
          n = seq_len;
          if (n >= span) begin
            bin = 0;
            w = 1;
            for (j = 0; j < k; j++) begin
              bin += window_syms[span - lag[j]] * w;
              w *= a;
            end
            bump_bin(bin);
          end
          if (it.last_symbol) begin
            if (circ_reg) begin
              if (n < span) begin
                res.status = lsth_pkg::STAT_SHORT;
              end else begin
                for (s = n - span + 1; s < n; s++) begin
                  bin = 0;
                  w = 1;
                  for (j = 0; j < k; j++) begin
                    p = s + lag[j] - 1;
                    x = (p < n) ? window_syms[n - 1 - p] : head_syms[p - n];
                    bin += x * w;
                    w *= a;
                  end
                  bump_bin(bin);
                end
              end
            end
            seq_len = 0;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic reg_set_t pack_settings(input int a, input int k, input int c,
                                             input int l1, input int l2, input int l3,
                                             input int l4);
    reg_set_t r;
    r[lsth_pkg::CFG_ALPHABET] = lsth_pkg::CFG_DATA_W'(a);
    r[lsth_pkg::CFG_TUPLE]    = lsth_pkg::CFG_DATA_W'(k);
    r[lsth_pkg::CFG_CIRCULAR] = lsth_pkg::CFG_DATA_W'(c);
    r[lsth_pkg::CFG_LAG1]     = lsth_pkg::CFG_DATA_W'(l1);
    r[lsth_pkg::CFG_LAG2]     = lsth_pkg::CFG_DATA_W'(l2);
    r[lsth_pkg::CFG_LAG3]     = lsth_pkg::CFG_DATA_W'(l3);
    r[lsth_pkg::CFG_LAG4]     = lsth_pkg::CFG_DATA_W'(l4);
    return r;
  endfunction

  function automatic int random_lag();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return $urandom_range(0, 31);
    if (sel == 1) return $urandom_range(7, 16);
    return $urandom_range(1, 6);
  endfunction

  function automatic reg_set_t random_settings();
    int a, k;
    a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
    k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
    return pack_settings(a, k, $urandom_range(0, 1), random_lag(), random_lag(),
                         random_lag(), random_lag());
  endfunction

  function automatic void add_item(input logic [lsth_pkg::CMD_W-1:0] cmd, input int sym,
                                   input bit last, input int bin, input bit typed,
                                   input int count, input lsth_pkg::status_t st);
    step_row_t row;
    row.settings = 1'b0;
    row.regs = '0;
    row.item.command = cmd;
    row.item.symbol = lsth_pkg::SYM_W'(sym);
    row.item.last_symbol = last;
    row.item.bin_index = lsth_pkg::BIN_W'(bin);
    row.typed = typed;
    row.want.bin_count = lsth_pkg::COUNT_W'(count);
    row.want.status = st;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_settings(input reg_set_t regs);
    step_row_t row;
    row.settings = 1'b1;
    row.regs = regs;
    row.item = '0;
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endfunction

  task automatic offer_item(input lsth_pkg::in_t it, input bit typed,
                            input lsth_pkg::out_t want);
    lsth_pkg::out_t got;
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = predict_tuple_step(it);
    pending_counts.push_back(typed ? want : got);
  endtask

  task automatic write_settings(input reg_set_t regs);
    int i;
    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    for (i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= lsth_pkg::CFG_IDX_W'(i);
      cfg_data <= regs[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_reg(lsth_pkg::CFG_IDX_W'(i), regs[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input int target);
    int             done_items, sel, len, i, a, span, reach;
    lsth_pkg::in_t  it;
    lsth_pkg::out_t none;
    none = '0;
    done_items = 0;
    while (done_items < target) begin
      a = eff_alpha();
      span = span_now();
      reach = a ** eff_tuple();
      sel = $urandom_range(0, 99);
      it.symbol = lsth_pkg::SYM_W'($urandom_range(0, 7));
      it.last_symbol = 1'($urandom_range(0, 1));
      it.bin_index = lsth_pkg::BIN_W'($urandom_range(0, 255));
      if (sel < 6) begin
        it.command = lsth_pkg::CMD_CLEAR;
        offer_item(it, 1'b0, none);
        done_items++;
      end else if (sel < 9) begin
        it.command = CMD_UNKNOWN;
        offer_item(it, 1'b0, none);
        done_items++;
      end else if (sel < 72) begin
        len = $urandom_range(1, 2 * span + 3);
        for (i = 0; i < len; i++) begin
          it.command = lsth_pkg::CMD_PUSH;
          it.symbol = ($urandom_range(0, 19) == 0) ? lsth_pkg::SYM_W'($urandom_range(0, 7))
                                                   : lsth_pkg::SYM_W'($urandom_range(1, a));
          it.last_symbol = (i == len - 1);
          it.bin_index = lsth_pkg::BIN_W'($urandom_range(0, 255));
          offer_item(it, 1'b0, none);
        end
        done_items += len;
      end else begin
        len = $urandom_range(1, 4);
        for (i = 0; i < len; i++) begin
          it.command = lsth_pkg::CMD_READ;
          it.bin_index = $urandom_range(0, 1) ? lsth_pkg::BIN_W'($urandom_range(0, reach - 1))
                                              : lsth_pkg::BIN_W'($urandom_range(0, 255));
          offer_item(it, 1'b0, none);
        end
        done_items += len;
      end
    end
  endtask

  always @(posedge clk) out_stall <= hold_on || ($urandom_range(0, 99) < recv_idle);

  initial begin : receiver_hold
    wait (hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin : check_results
    lsth_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        if (mismatch_count < REPORT_MAX)
          $display("unexpected transfer: count %0d status %0d",
                   out_data.bin_count, out_data.status);
        mismatch_count++;
      end else begin
        want = pending_counts.pop_front();
        if (out_data.bin_count !== want.bin_count || out_data.status !== want.status) begin
          if (mismatch_count < REPORT_MAX)
            $display("mismatch: count exp %0d got %0d, status exp %0d got %0d",
                     want.bin_count, out_data.bin_count, want.status, out_data.status);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    reg_set_t presets [4];
    int       phase, r;
    reset_predictor();
    presets[0] = pack_settings(4, 4, 1, 1, 5, 10, 16);
    presets[1] = pack_settings(1, 1, 0, 1, 1, 1, 1);
    presets[2] = pack_settings(0, 7, 1, 0, 31, 16, 2);
    presets[3] = pack_settings(4, 3, 0, 16, 8, 16, 1);

    add_item(lsth_pkg::CMD_READ, 1, 1'b0, 0, 1'b1, 0, lsth_pkg::STAT_OK);
    add_item(lsth_pkg::CMD_READ, 6, 1'b1, 255, 1'b1, 0, lsth_pkg::STAT_OK);
    add_item(CMD_UNKNOWN, 7, 1'b1, 170, 1'b1, 0, lsth_pkg::STAT_OK);
    add_item(lsth_pkg::CMD_CLEAR, 0, 1'b0, 85, 1'b1, 0, lsth_pkg::STAT_OK);
    add_item(lsth_pkg::CMD_PUSH, 0, 1'b0, 0, 1'b1, 0, lsth_pkg::STAT_BAD_SYM);
    add_item(lsth_pkg::CMD_PUSH, 7, 1'b1, 255, 1'b1, 0, lsth_pkg::STAT_BAD_SYM);
    add_item(lsth_pkg::CMD_PUSH, 5, 1'b0, 0, 1'b1, 0, lsth_pkg::STAT_BAD_SYM);
    add_item(lsth_pkg::CMD_PUSH, 1, 1'b0, 0, 1'b0, 0, lsth_pkg::STAT_OK);
    add_item(lsth_pkg::CMD_PUSH, 4, 1'b0, 0, 1'b0, 0, lsth_pkg::STAT_OK);
    add_item(lsth_pkg::CMD_PUSH, 2, 1'b1, 0, 1'b0, 0, lsth_pkg::STAT_OK);
    add_item(lsth_pkg::CMD_READ, 0, 1'b0, 12, 1'b0, 0, lsth_pkg::STAT_OK);
    add_item(lsth_pkg::CMD_READ, 0, 1'b0, 7, 1'b0, 0, lsth_pkg::STAT_OK);
    add_item(lsth_pkg::CMD_PUSH, 3, 1'b1, 0, 1'b0, 0, lsth_pkg::STAT_OK);
    add_settings(pack_settings(4, 2, 1, 1, 2, 3, 4));
    add_item(lsth_pkg::CMD_PUSH, 2, 1'b1, 0, 1'b1, 0, lsth_pkg::STAT_SHORT);
    add_item(lsth_pkg::CMD_PUSH, 1, 1'b0, 0, 1'b0, 0, lsth_pkg::STAT_OK);
    add_item(lsth_pkg::CMD_PUSH, 2, 1'b0, 0, 1'b0, 0, lsth_pkg::STAT_OK);
    add_item(lsth_pkg::CMD_PUSH, 3, 1'b0, 0, 1'b0, 0, lsth_pkg::STAT_OK);
    add_item(lsth_pkg::CMD_PUSH, 4, 1'b1, 0, 1'b0, 0, lsth_pkg::STAT_OK);
    add_item(lsth_pkg::CMD_READ, 0, 1'b0, 4, 1'b0, 0, lsth_pkg::STAT_OK);
    add_item(lsth_pkg::CMD_READ, 0, 1'b0, 3, 1'b0, 0, lsth_pkg::STAT_OK);
    add_settings(pack_settings(0, 0, 1, 0, 2, 3, 4));
    add_item(lsth_pkg::CMD_PUSH, 1, 1'b1, 0, 1'b0, 0, lsth_pkg::STAT_OK);
    add_item(lsth_pkg::CMD_PUSH, 2, 1'b0, 0, 1'b1, 0, lsth_pkg::STAT_BAD_SYM);
    add_item(lsth_pkg::CMD_READ, 0, 1'b0, 0, 1'b0, 0, lsth_pkg::STAT_OK);
    add_item(lsth_pkg::CMD_CLEAR, 0, 1'b0, 0, 1'b1, 0, lsth_pkg::STAT_OK);
    add_item(lsth_pkg::CMD_READ, 0, 1'b0, 0, 1'b1, 0, lsth_pkg::STAT_OK);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < directed_rows.size(); r++) begin
      if (directed_rows[r].settings) write_settings(directed_rows[r].regs);
      else offer_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      write_settings((phase < 4) ? presets[phase] : random_settings());
      case (phase / 4)
        0: begin
          send_idle = 32;
          recv_idle = 59;
        end
        1: begin
          send_idle = 59;
          recv_idle = 32;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      if (phase == 2) hold_go = 1'b1;
      run_random_phase(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_counts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
